### hw/rtl/psc_pkg.sv
// Shared types and constants for the prime sieve counter.
// Holds the micro-op and condition codes, the control word and the program table.
// No dependencies.
package psc_pkg;

   localparam int BOUND_W = 16;
   localparam int COUNT_W = 13;
   localparam int UPC_W   = 4;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_RINIT,
      OP_FILL,
      OP_SQRT,
      OP_PINIT,
      OP_PREAD,
      OP_KINIT,
      OP_MARK,
      OP_PNEXT,
      OP_CINIT,
      OP_COUNT,
      OP_RESP
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_ZERO,
      C_K_LT_N,
      C_K_LE_N,
      C_SQ_LE_N,
      C_P_DONE,
      C_FLAG_CLR,
      C_N_LT2,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      logic no_req;
      logic zero;
      logic k_lt_n;
      logic k_le_n;
      logic sq_le_n;
      logic p_done;
      logic flag_clr;
      logic n_lt2;
      logic out_busy;
   } psc_flags_type;

   localparam upc_type ST_IDLE   = 4'd0;
   localparam upc_type ST_CHECK  = 4'd1;
   localparam upc_type ST_FILL   = 4'd2;
   localparam upc_type ST_ROOT   = 4'd3;
   localparam upc_type ST_PINIT  = 4'd4;
   localparam upc_type ST_PTEST  = 4'd5;
   localparam upc_type ST_PCHECK = 4'd6;
   localparam upc_type ST_MARK   = 4'd7;
   localparam upc_type ST_PNEXT  = 4'd8;
   localparam upc_type ST_CINIT  = 4'd9;
   localparam upc_type ST_COUNT  = 4'd10;
   localparam upc_type ST_CWAIT  = 4'd11;
   localparam upc_type ST_RESP   = 4'd12;
   localparam upc_type ST_DONE   = 4'd13;

   function automatic uword_type psc_rom(upc_type addr);
      uword_type w;
      case (addr)
         ST_IDLE:   w = '{op: OP_ACCEPT, cond: C_NO_REQ,   target: ST_IDLE};
         ST_CHECK:  w = '{op: OP_RINIT,  cond: C_ZERO,     target: ST_RESP};
         ST_FILL:   w = '{op: OP_FILL,   cond: C_K_LT_N,   target: ST_FILL};
         ST_ROOT:   w = '{op: OP_SQRT,   cond: C_SQ_LE_N,  target: ST_ROOT};
         ST_PINIT:  w = '{op: OP_PINIT,  cond: C_NEVER,    target: ST_IDLE};
         ST_PTEST:  w = '{op: OP_PREAD,  cond: C_P_DONE,   target: ST_CINIT};
         ST_PCHECK: w = '{op: OP_KINIT,  cond: C_FLAG_CLR, target: ST_PNEXT};
         ST_MARK:   w = '{op: OP_MARK,   cond: C_K_LE_N,   target: ST_MARK};
         ST_PNEXT:  w = '{op: OP_PNEXT,  cond: C_ALWAYS,   target: ST_PTEST};
         ST_CINIT:  w = '{op: OP_CINIT,  cond: C_N_LT2,    target: ST_CWAIT};
         ST_COUNT:  w = '{op: OP_COUNT,  cond: C_K_LT_N,   target: ST_COUNT};
         ST_CWAIT:  w = '{op: OP_NOP,    cond: C_NEVER,    target: ST_IDLE};
         ST_RESP:   w = '{op: OP_RESP,   cond: C_OUT_BUSY, target: ST_RESP};
         ST_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_IDLE};
         default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic int psc_isqrt(int v);
      int r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) begin
         r = r + 1;
      end
      return r;
   endfunction

endpackage

### hw/rtl/prime_sieve_counter.sv
// Prime sieve counter top level: datapath, flag memory and sequencer.
// Depends on psc_pkg, psc_seq and psc_ram.
//
//   channel | direction | ports                                  | moves
//   req     | in        | req_valid, req_stall, req_upper_bound  | one bound per word
//   rsp     | out       | rsp_valid, rsp_stall, rsp_prime_count,  | one count per word
//           |           | rsp_bad_bound                          |
//
// The flag memory has one write port and one read port, so one flag is written or read
// per cycle in the fill, mark and count sweeps. A zero bound skips the sweeps and goes
// straight to the response. Reset clears control state only; flags are always written
// before they are read, so there is no clearing pass.
// A finished word waits in the output register while the next bound is taken.
module prime_sieve_counter #(
   parameter int MAX_BOUND = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [psc_pkg::BOUND_W-1:0]   req_upper_bound,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [psc_pkg::COUNT_W-1:0]   rsp_prime_count,
   output logic                          rsp_bad_bound
);
   import psc_pkg::*;

   localparam int DEPTH    = MAX_BOUND + 1;
   localparam int AW       = $clog2(DEPTH);
   localparam int KW       = AW + 1;
   localparam int MAX_ROOT = psc_isqrt(MAX_BOUND) + 1;
   localparam int RW       = $clog2(MAX_ROOT + 2);
   localparam logic [AW-1:0] N_MAX = AW'(MAX_BOUND);

   op_type        op;
   psc_flags_type flags;

   logic [AW-1:0]      n_ff, n_in;
   logic               zero_ff, zero_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      sq_ff, sq_in;
   logic [RW-1:0]      root_ff, root_in;
   logic [RW-1:0]      p_ff, p_in;
   logic [KW-1:0]      psq_ff, psq_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               cnt_en_ff, cnt_en_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic          accept;
   logic          rsp_free;
   logic [KW-1:0] n_ext;
   logic [KW-1:0] p_ext;
   logic [KW-1:0] root_ext;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic          ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic          ram_rd_data;

   psc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   psc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_flags (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (op != OP_ACCEPT);
   assign accept    = req_valid && (op == OP_ACCEPT);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign n_ext     = KW'(n_ff);
   assign p_ext     = KW'(p_ff);
   assign root_ext  = KW'(root_ff);

   always_comb begin
      flags.no_req   = !req_valid;
      flags.zero     = zero_ff;
      flags.k_lt_n   = (k_ff < n_ext);
      flags.k_le_n   = (k_ff <= n_ext);
      flags.sq_le_n  = (sq_ff <= n_ext);
      flags.p_done   = (p_ff > root_ff) || (p_ext > n_ext);
      flags.flag_clr = !ram_rd_data;
      flags.n_lt2    = (n_ff < AW'(2));
      flags.out_busy = !rsp_free;
   end

   always_comb begin
      n_in         = n_ff;
      zero_in      = zero_ff;
      k_in         = k_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      p_in         = p_ff;
      psq_in       = psq_ff;
      count_in     = count_ff;
      cnt_en_in    = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = k_ff[AW-1:0];
      ram_wr_data  = 1'b0;
      ram_rd_addr  = k_ff[AW-1:0];

      if (cnt_en_ff) begin
         count_in = count_ff + {{(COUNT_W-1){1'b0}}, ram_rd_data};
      end

      case (op)
         OP_ACCEPT: begin
            if (accept) begin
               zero_in  = (req_upper_bound == '0);
               count_in = '0;
               if ({16'b0, req_upper_bound} > 32'(MAX_BOUND)) begin
                  n_in = N_MAX;
               end else begin
                  n_in = AW'(req_upper_bound);
               end
            end
         end
         OP_RINIT: begin
            if (!zero_ff) begin
               k_in    = KW'(2);
               sq_in   = KW'(1);
               root_in = RW'(1);
            end
         end
         OP_FILL: begin
            ram_wr_en   = flags.k_le_n;
            ram_wr_data = 1'b1;
            k_in        = k_ff + KW'(1);
         end
         OP_SQRT: begin
            if (flags.sq_le_n) begin
               sq_in   = sq_ff + (root_ext << 1) + KW'(1);
               root_in = root_ff + RW'(1);
            end
         end
         OP_PINIT: begin
            p_in   = RW'(2);
            psq_in = KW'(4);
         end
         OP_PREAD: begin
            ram_rd_addr = AW'(p_ff);
         end
         OP_KINIT: begin
            k_in = psq_ff;
         end
         OP_MARK: begin
            ram_wr_en   = flags.k_le_n;
            ram_wr_data = 1'b0;
            k_in        = k_ff + p_ext;
         end
         OP_PNEXT: begin
            psq_in = psq_ff + (p_ext << 1) + KW'(1);
            p_in   = p_ff + RW'(1);
         end
         OP_CINIT: begin
            k_in = KW'(2);
         end
         OP_COUNT: begin
            cnt_en_in = 1'b1;
            k_in      = k_ff + KW'(1);
         end
         OP_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_bad_in   = zero_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         cnt_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         cnt_en_ff    <= cnt_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      zero_ff      <= zero_in;
      k_ff         <= k_in;
      sq_ff        <= sq_in;
      p_ff         <= p_in;
      psq_ff       <= psq_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign rsp_bad_bound   = rsp_bad_ff;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (ram_wr_addr <= n_ff))
      else $error("flag write beyond the bound");

   a_bad_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_bound) |-> (rsp_prime_count == '0))
      else $error("bad bound word with non-zero count");

   a_sieve_p_range: assert property (@(posedge clock) disable iff (reset)
      (op == OP_KINIT) |-> ((p_ff <= root_ff) && (p_ext <= n_ext)))
      else $error("sieving with a candidate past the root or bound");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (op != OP_ACCEPT))
      else $error("sequencer stayed idle after taking a word");

endmodule

### hw/rtl/psc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/psc_seq.sv
// Microcode sequencer: step counter, program table and jump conditions.
// Depends on psc_pkg.
module psc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  psc_pkg::psc_flags_type flags,
   output psc_pkg::op_type        op
);
   import psc_pkg::*;

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type uw;
   logic      take;

   always_comb begin
      uw = psc_rom(upc_ff);
      case (uw.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = flags.no_req;
         C_ZERO:     take = flags.zero;
         C_K_LT_N:   take = flags.k_lt_n;
         C_K_LE_N:   take = flags.k_le_n;
         C_SQ_LE_N:  take = flags.sq_le_n;
         C_P_DONE:   take = flags.p_done;
         C_FLAG_CLR: take = flags.flag_clr;
         C_N_LT2:    take = flags.n_lt2;
         C_OUT_BUSY: take = flags.out_busy;
         default:    take = 1'b0;
      endcase
      upc_in = take ? uw.target : upc_ff + upc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign op = uw.op;

endmodule

### tb/tb_prime_sieve_counter.sv
// Testbench for prime_sieve_counter: drives upper bounds, checks counts and the bad-bound flag.
// Predicts each word with its own sieve; random idle bursts on both channels, none at the tail.
// Depends on psc_pkg and the prime_sieve_counter RTL.
`timescale 1ns / 100ps

module tb_prime_sieve_counter;

   import psc_pkg::*;

   localparam int MAX_BOUND = 65535;

   typedef struct packed {
      logic [COUNT_W-1:0] prime_count;
      logic               bad_bound;
   } sieve_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BOUND_W-1:0] req_upper_bound = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COUNT_W-1:0] rsp_prime_count;
   logic               rsp_bad_bound;

   logic [BOUND_W-1:0] pending_bounds[$];
   sieve_result_type   expected_counts[$];
   bit                 sieve_flags [0:MAX_BOUND];

   logic    req_taken = 1'b0;
   int      send_gap = 0;
   int      hold_left = 0;
   longint  cycle_count = 0;
   longint  run_limit = 20000;
   int      mismatch_count = 0;
   int      counts_seen = 0;
   int      zero_bounds_seen = 0;
   int      largest_bound = 0;
   bit      timed_out;

   prime_sieve_counter #(.MAX_BOUND(MAX_BOUND)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_upper_bound (req_upper_bound),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_count (rsp_prime_count),
      .rsp_bad_bound   (rsp_bad_bound)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic sieve_result_type sieve_count(logic [BOUND_W-1:0] bound);
      sieve_result_type r;
      int n, p, k, root, total;
      r = '0;
      n = bound;
      if (n == 0) begin
         r.bad_bound = 1'b1;
         return r;
      end
      if (n > MAX_BOUND)
         n = MAX_BOUND;
      for (k = 2; k <= n; k++)
         sieve_flags[k] = 1'b1;
      root = 0;
      while ((root + 1) * (root + 1) <= n)
         root++;
      for (p = 2; p <= root + 1 && p <= n; p++) begin
         if (sieve_flags[p]) begin
            for (k = p * p; k <= n; k += p)
               sieve_flags[k] = 1'b0;
         end
      end
      total = 0;
      for (k = 2; k <= n; k++)
         total += int'(sieve_flags[k]);
      r.prime_count = total[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [BOUND_W-1:0] random_bound();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return '0;
      else if (pick < 10)
         return BOUND_W'($urandom_range(1, 3));
      else if (pick < 75)
         return BOUND_W'($urandom_range(4, 200));
      else if (pick < 95)
         return BOUND_W'($urandom_range(201, 2000));
      else
         return BOUND_W'($urandom_range(2001, 12000));
   endfunction

   // request side: hold a stalled word, otherwise advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bounds.size() != 0) begin
            req_valid <= 1'b1;
            req_upper_bound <= pending_bounds.pop_front();
            if (pending_bounds.size() > 12 && $urandom_range(0, 3) == 0)
               send_gap <= $urandom_range(1, 18);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: stall in bursts, none at the tail
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (pending_bounds.size() > 12 && $urandom_range(0, 7) == 0)
            hold_left <= $urandom_range(1, 18);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      sieve_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_counts.push_back(sieve_count(req_upper_bound));
            if (req_upper_bound == 0)
               zero_bounds_seen++;
            if (int'(req_upper_bound) > largest_bound)
               largest_bound = int'(req_upper_bound);
         end
         if (rsp_valid && !rsp_stall) begin
            counts_seen++;
            if (expected_counts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: count=%0d bad_bound=%0b",
                           rsp_prime_count, rsp_bad_bound);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_prime_count !== want.prime_count ||
                   rsp_bad_bound !== want.bad_bound) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected count=%0d bad_bound=%0b, ",
                               "got count=%0d bad_bound=%0b"},
                              want.prime_count, want.bad_bound,
                              rsp_prime_count, rsp_bad_bound);
               end
            end
         end
      end
   end

   initial begin
      logic [BOUND_W-1:0] directed[$];
      directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd0, 16'd1, 16'd25, 16'd49,
                   16'd120, 16'd121, 16'd255, 16'd256, 16'd2047, 16'd32768, 16'd65535,
                   16'd7, 16'd8};
      foreach (directed[i])
         pending_bounds.push_back(directed[i]);
      repeat (90)
         pending_bounds.push_back(random_bound());
      foreach (pending_bounds[i])
         run_limit += 16 * longint'(pending_bounds[i]) + 256;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while ((pending_bounds.size() != 0 || req_valid || expected_counts.size() != 0)
             && cycle_count < run_limit)
         @(negedge clock);
      timed_out = cycle_count >= run_limit;
      if (!timed_out)
         repeat (64) @(negedge clock);

      if (timed_out)
         $display("timeout after %0d cycles", cycle_count);
      if (expected_counts.size() != 0)
         $display("%0d words never arrived", expected_counts.size());
      $display("%0d counts checked (%0d zero bounds), largest bound %0d, %0d mismatches",
               counts_seen, zero_bounds_seen, largest_bound, mismatch_count);
      if (!timed_out && mismatch_count == 0 && expected_counts.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
hw/rtl/psc_pkg.sv
hw/rtl/psc_ram.sv
hw/rtl/psc_seq.sv
hw/rtl/prime_sieve_counter.sv
tb/tb_prime_sieve_counter.sv
